// File: hdl/integer_literal_scanner_top_assert.svh
// Assertion macros for the integer literal scanner checker.
`ifndef INTEGER_LITERAL_SCANNER_TOP_ASSERT_SVH
`define INTEGER_LITERAL_SCANNER_TOP_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define ILS_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Check a property at every clock edge, reset included.
`define ILS_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: hdl/ils_pkg.sv
// Types, constants and character decode shared by the integer literal scanner.
package ils_pkg;

  localparam int VALUE_BITS = 64;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int PROD_W     = VALUE_BITS + RADIX_W;

  localparam logic [RADIX_W-1:0] RADIX_BIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_OCT = RADIX_W'(8);
  localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_HEX = RADIX_W'(16);
  localparam logic [RADIX_W-1:0] RADIX_B36 = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPR_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LWR_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LWR_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_LWR_B = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LWR_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PREFIX = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
    status_e               status;
    logic [RADIX_W-1:0]    bad_digit;
  } res_t;

  typedef struct packed {
    logic               is_alnum;
    logic [RADIX_W-1:0] val;
  } digit_t;

  function automatic digit_t digit_decode(logic [CHAR_W-1:0] c);
    digit_t d;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.is_alnum = 1'b1;
      d.val      = RADIX_W'(c - CH_ZERO);
    end else if (c >= CH_UPR_A && c <= CH_UPR_Z) begin
      d.is_alnum = 1'b1;
      d.val      = RADIX_W'(c - CH_UPR_A) + RADIX_W'(10);
    end else if (c >= CH_LWR_A && c <= CH_LWR_Z) begin
      d.is_alnum = 1'b1;
      d.val      = RADIX_W'(c - CH_LWR_A) + RADIX_W'(10);
    end
    return d;
  endfunction

  function automatic logic [PROD_W-1:0] mul_radix(logic [VALUE_BITS-1:0] a,
                                                  logic [RADIX_W-1:0] r);
    logic [PROD_W-1:0] x;
    logic [PROD_W-1:0] p;
    x = PROD_W'(a);
    unique case (r)
      RADIX_BIN: p = x << 1;
      RADIX_OCT: p = x << 3;
      RADIX_HEX: p = x << 4;
      RADIX_B36: p = (x << 5) + (x << 2);
      default:   p = (x << 3) + (x << 1);
    endcase
    return p;
  endfunction

endpackage

// File: hdl/ils_if.sv
// Request and result channel interfaces of the integer literal scanner.
interface ils_in_if import ils_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              literal_start;

  modport source (output valid, output char_code, output literal_start, input ready);
  modport sink (input valid, input char_code, input literal_start, output ready);
endinterface

interface ils_out_if import ils_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [RADIX_W-1:0]    radix;
  logic [1:0]            status;
  logic [RADIX_W-1:0]    bad_digit;

  modport source (output valid, output value, output radix, output status,
                  output bad_digit, input ready);
  modport sink (input valid, input value, input radix, input status,
                input bad_digit, output ready);
endinterface

// File: hdl/ils_core.sv
// Scanner state and combinational digit accumulate, range and overflow check.
module ils_core import ils_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic                literal_start_i,
  output logic                res_valid_o,
  output res_t                res_o
);

  phase_e                phase_q, phase_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [RADIX_W-1:0]    radix_q, radix_d;

  digit_t                dig;
  logic [RADIX_W-1:0]    radix_use;
  logic [PROD_W-1:0]     sum;
  logic                  do_digit;

  assign dig = digit_decode(char_code_i);
  assign sum = mul_radix(acc_q, radix_use) + PROD_W'(dig.val);

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    radix_d     = radix_q;
    radix_use   = radix_q;
    do_digit    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      if (literal_start_i) begin
        radix_d = RADIX_DEC;
        acc_d   = '0;
        if (char_code_i == CH_ZERO) begin
          phase_d = PH_PREFIX;
        end else if (char_code_i >= CH_ONE && char_code_i <= CH_NINE) begin
          acc_d   = VALUE_BITS'(char_code_i - CH_ZERO);
          phase_d = PH_DIGITS;
        end else begin
          phase_d = PH_IDLE;
        end
      end else begin
        unique case (phase_q)
          PH_PREFIX: begin
            phase_d = PH_DIGITS;
            priority if (char_code_i == CH_LWR_B) begin
              radix_d = RADIX_BIN;
            end else if (char_code_i == CH_LWR_X) begin
              radix_d = RADIX_HEX;
            end else if (char_code_i == CH_HASH) begin
              radix_d = RADIX_B36;
            end else begin
              radix_use = (char_code_i >= CH_ZERO && char_code_i <= CH_NINE) ?
                          RADIX_OCT : RADIX_DEC;
              radix_d   = radix_use;
              do_digit  = 1'b1;
            end
          end
          PH_DIGITS: do_digit = 1'b1;
          default:   do_digit = 1'b0;
        endcase
        if (do_digit) begin
          res_o.radix = radix_use;
          priority if (!dig.is_alnum) begin
            res_valid_o  = 1'b1;
            res_o.value  = acc_q;
            res_o.status = ST_OK;
            phase_d      = PH_IDLE;
          end else if (dig.val >= radix_use) begin
            res_valid_o     = 1'b1;
            res_o.status    = ST_RANGE;
            res_o.bad_digit = dig.val;
            phase_d         = PH_IDLE;
          end else if (|sum[PROD_W-1:VALUE_BITS]) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_OVERFLOW;
            phase_d      = PH_IDLE;
          end else begin
            acc_d = sum[VALUE_BITS-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      radix_q <= RADIX_DEC;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      radix_q <= radix_d;
    end
  end

endmodule

// File: hdl/integer_literal_scanner_top.sv
// Integer literal scanner top level: request intake, scan core, two-entry result buffer.
// The request that ends a literal has its result registered in the output register, or in the skid entry on a stall.
// Throughput: one request per cycle while the skid entry is empty; the scan step is a single registered pass.
// Results land in an output register backed by one skid entry, so one result may wait.
// Reset: asynchronous, active low; clears the scan state (idle, zero, radix ten)
// and empties the result buffer.
module integer_literal_scanner_top import ils_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ils_in_if.sink     req_i,
  ils_out_if.source  res_o
);

  logic accept;
  logic r_valid;
  res_t r_data;

  logic main_valid_q;
  res_t main_q;
  logic skid_valid_q;
  res_t skid_q;
  logic pop;

  assign req_i.ready = !skid_valid_q;
  assign accept      = req_i.valid && req_i.ready;
  assign pop         = main_valid_q && res_o.ready;

  ils_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .char_code_i     (req_i.char_code),
    .literal_start_i (req_i.literal_start),
    .res_valid_o     (r_valid),
    .res_o           (r_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !main_valid_q) begin
      main_valid_q <= skid_valid_q || r_valid;
      skid_valid_q <= 1'b0;
    end else if (r_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !main_valid_q) begin
      main_q <= skid_valid_q ? skid_q : r_data;
    end else if (r_valid) begin
      skid_q <= r_data;
    end
  end

  assign res_o.valid     = main_valid_q;
  assign res_o.value     = main_q.value;
  assign res_o.radix     = main_q.radix;
  assign res_o.status    = main_q.status;
  assign res_o.bad_digit = main_q.bad_digit;

endmodule

// File: hdl/ils_checker.sv
// Port-level checker for the integer literal scanner and its bind.
`include "integer_literal_scanner_top_assert.svh"

module ils_checker import ils_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [VALUE_BITS-1:0] value_i,
  input logic [RADIX_W-1:0]    radix_i,
  input logic [1:0]            status_i,
  input logic [RADIX_W-1:0]    bad_digit_i
);

  `ILS_ASSERT_RST(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_i, "result during reset")

  `ILS_ASSERT(a_hold_stalled, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(value_i) && $stable(status_i) && $stable(radix_i) && $stable(bad_digit_i), "stalled result changed")

  `ILS_ASSERT(a_result_needs_request, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i), "result without a request")

  `ILS_ASSERT(a_radix_legal, clk_i, rst_ni, out_valid_i |-> (radix_i == RADIX_BIN || radix_i == RADIX_OCT || radix_i == RADIX_DEC || radix_i == RADIX_HEX || radix_i == RADIX_B36), "illegal radix")

  `ILS_ASSERT(a_status_fields, clk_i, rst_ni, out_valid_i |-> (status_i == ST_OK && bad_digit_i == '0) || (status_i == ST_RANGE && value_i == '0 && bad_digit_i >= radix_i) || (status_i == ST_OVERFLOW && value_i == '0 && bad_digit_i == '0), "inconsistent status fields")

endmodule

bind integer_literal_scanner_top ils_checker u_ils_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .value_i     (res_o.value),
  .radix_i     (res_o.radix),
  .status_i    (res_o.status),
  .bad_digit_i (res_o.bad_digit)
);
